### rtl/csc_pkg.sv
// ----------------------------------------------------------------------------
// csc_pkg
// Shared types, codes and constant tables of the C source colorizer.
// ----------------------------------------------------------------------------
package csc_pkg;

  typedef enum logic [2:0] {
    CLS_PLAIN   = 3'd0,
    CLS_KEYWORD = 3'd1,
    CLS_HASH    = 3'd2,
    CLS_LITERAL = 3'd3,
    CLS_COMMENT = 3'd4,
    CLS_DIGIT   = 3'd5
  } colour_class_e;

  typedef enum logic [2:0] {
    MODE_CODE   = 3'd0,
    MODE_BLOCK  = 3'd1,
    MODE_LINE   = 3'd2,
    MODE_STRING = 3'd3,
    MODE_CHAR   = 3'd4
  } lex_mode_e;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEYWORD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HASH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LITERAL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COMMENT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIGIT   = 3'd5;

  localparam logic [7:0] RST_DEFAULT = 8'h07;
  localparam logic [7:0] RST_KEYWORD = 8'h0B;
  localparam logic [7:0] RST_HASH    = 8'h0C;
  localparam logic [7:0] RST_LITERAL = 8'h0D;
  localparam logic [7:0] RST_COMMENT = 8'h02;
  localparam logic [7:0] RST_DIGIT   = 8'h0E;

  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_HASH      = 8'h23;

  localparam int unsigned KW_COUNT   = 31;
  localparam int unsigned KW_MAX_LEN = 8;

  localparam logic [8*KW_MAX_LEN-1:0] KW_TABLE [KW_COUNT] = '{
    64'("int"),      64'("char"),     64'("void"),     64'("if"),
    64'("else"),     64'("for"),      64'("while"),    64'("return"),
    64'("struct"),   64'("typedef"),  64'("switch"),   64'("case"),
    64'("break"),    64'("continue"), 64'("do"),       64'("goto"),
    64'("static"),   64'("extern"),   64'("const"),    64'("unsigned"),
    64'("signed"),   64'("long"),     64'("short"),    64'("float"),
    64'("double"),   64'("enum"),     64'("union"),    64'("volatile"),
    64'("register"), 64'("auto"),     64'("sizeof")
  };

  typedef struct packed {
    logic [7:0] text_byte;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0]    out_byte;
    logic [7:0]    column;
    colour_class_e colour_class;
    logic [7:0]    attribute;
    logic          run_last;
    logic          line_last;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic emit_flush;
    logic emit_direct;
  } ctrl_cmd_t;

  typedef struct packed {
    logic flush_any;
    logic direct_any;
    logic flush_end;
    logic direct_held;
    logic out_free;
  } ctrl_sts_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           is_digit(c) || (c == 8'h5F);
  endfunction

endpackage

### rtl/csc_ctrl.sv
// ----------------------------------------------------------------------------
// csc_ctrl
// Sequencer: takes one character, then drains the held word and the
// character's own result into the output register.
// ----------------------------------------------------------------------------
module csc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  csc_pkg::ctrl_sts_t  sts_i,
  output csc_pkg::ctrl_cmd_t  cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_FLUSH  = 2'd1;
  localparam logic [1:0] ST_DIRECT = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d           = state_q;
    in_stall_o        = 1'b1;
    cmd_o.accept      = 1'b0;
    cmd_o.emit_flush  = 1'b0;
    cmd_o.emit_direct = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.flush_any) begin
            state_d = ST_FLUSH;
          end else if (sts_i.direct_any) begin
            state_d = ST_DIRECT;
          end
        end
      end
      ST_FLUSH: begin
        if (sts_i.out_free) begin
          cmd_o.emit_flush = 1'b1;
          if (sts_i.flush_end) begin
            state_d = sts_i.direct_held ? ST_DIRECT : ST_IDLE;
          end
        end
      end
      ST_DIRECT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_direct = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/csc_datapath.sv
// ----------------------------------------------------------------------------
// csc_datapath
// Lexer state, held word store, keyword match, colour registers and the
// output register.
// ----------------------------------------------------------------------------
module csc_datapath #(
  parameter int unsigned WORD_HOLD   = 8,
  parameter int unsigned LINE_LENGTH = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  csc_pkg::ctrl_cmd_t                  cmd_i,
  output csc_pkg::ctrl_sts_t                  sts_o,
  input  csc_pkg::in_item_t                   in_data_i,
  input  logic                                cfg_valid_i,
  input  logic [csc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [7:0]                          cfg_data_i,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output csc_pkg::out_item_t                  out_data_o
);

  localparam int unsigned WIDX  = $clog2(WORD_HOLD);
  localparam int unsigned LEN_W = $clog2(WORD_HOLD + 1);
  localparam int unsigned COL_W = $clog2(LINE_LENGTH);
  localparam int unsigned SUM_W = COL_W + 1;
  localparam int unsigned KW_W  = 8 * csc_pkg::KW_MAX_LEN;

  // lexer state
  csc_pkg::lex_mode_e mode_q, mode_d;
  logic               slash_q, slash_d, star_q, star_d, esc_q, esc_d;
  logic               long_q, long_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [COL_W-1:0]   wcol_q, wcol_d;
  logic [7:0]         store_q [WORD_HOLD];

  // pending results of the accepted item
  logic [LEN_W-1:0]      flen_q, fn;
  logic                  nokw_q, nokw;
  logic                  dv_q, dv;
  logic [7:0]            dbyte_q;
  csc_pkg::colour_class_e dcls_q, dcls;
  logic [COL_W-1:0]      dcol_q;
  logic                  last_q;
  logic [WIDX-1:0]       k_q;
  logic                  hold;

  logic [7:0] reg_default_q, reg_keyword_q, reg_hash_q;
  logic [7:0] reg_literal_q, reg_comment_q, reg_digit_q;

  logic               out_valid_q;
  csc_pkg::out_item_t out_q, out_d;

  logic [7:0]       c;
  logic [SUM_W-1:0] col_inc;
  logic [SUM_W-1:0] fcol_sum;
  logic [COL_W-1:0] fcol;
  logic [KW_W-1:0]  word_val;
  logic             kw_hit;
  logic             flush_end;
  logic [7:0]       fbyte;
  csc_pkg::colour_class_e fcls, ocls;

  function automatic logic [7:0] attr_of(
    input csc_pkg::colour_class_e cls,
    input logic [7:0] a_def, input logic [7:0] a_kw, input logic [7:0] a_hash,
    input logic [7:0] a_lit, input logic [7:0] a_com, input logic [7:0] a_dig
  );
    logic [7:0] a;
    case (cls)
      csc_pkg::CLS_KEYWORD: a = a_kw;
      csc_pkg::CLS_HASH:    a = a_hash;
      csc_pkg::CLS_LITERAL: a = a_lit;
      csc_pkg::CLS_COMMENT: a = a_com;
      csc_pkg::CLS_DIGIT:   a = a_dig;
      default:              a = a_def;
    endcase
    return a;
  endfunction

  // next lexer state for the offered character
  always_comb begin
    c       = in_data_i.text_byte;
    mode_d  = mode_q;
    slash_d = slash_q;
    star_d  = star_q;
    esc_d   = esc_q;
    long_d  = long_q;
    len_d   = len_q;
    wcol_d  = wcol_q;
    hold    = 1'b0;
    dv      = 1'b1;
    dcls    = csc_pkg::CLS_PLAIN;
    fn      = '0;
    nokw    = 1'b0;
    col_inc = SUM_W'(col_q) + SUM_W'(1);
    case (mode_q)
      csc_pkg::MODE_BLOCK: begin
        if (star_q && (c == csc_pkg::CH_SLASH)) begin
          mode_d = csc_pkg::MODE_CODE;
          star_d = 1'b0;
        end else begin
          star_d = (c == csc_pkg::CH_STAR);
          dcls   = csc_pkg::CLS_COMMENT;
        end
      end
      csc_pkg::MODE_LINE: begin
        dcls = csc_pkg::CLS_COMMENT;
      end
      csc_pkg::MODE_STRING, csc_pkg::MODE_CHAR: begin
        dcls = csc_pkg::CLS_LITERAL;
        if (esc_q) begin
          esc_d = 1'b0;
        end else if (c == csc_pkg::CH_BACKSLASH) begin
          esc_d = 1'b1;
        end else if (c == ((mode_q == csc_pkg::MODE_STRING) ? csc_pkg::CH_DQUOTE
                                                            : csc_pkg::CH_SQUOTE)) begin
          mode_d = csc_pkg::MODE_CODE;
        end
      end
      default: begin
        slash_d = 1'b0;
        if (slash_q && ((c == csc_pkg::CH_SLASH) || (c == csc_pkg::CH_STAR))) begin
          mode_d = (c == csc_pkg::CH_SLASH) ? csc_pkg::MODE_LINE : csc_pkg::MODE_BLOCK;
          star_d = 1'b0;
          dcls   = csc_pkg::CLS_COMMENT;
        end else if (csc_pkg::is_word(c)) begin
          dcls = csc_pkg::is_digit(c) ? csc_pkg::CLS_DIGIT : csc_pkg::CLS_PLAIN;
          if (long_q) begin
            dv = 1'b1;
          end else if (len_q < LEN_W'(WORD_HOLD)) begin
            hold = 1'b1;
            dv   = 1'b0;
            if (len_q == '0) begin
              wcol_d = col_q;
            end
            len_d = len_q + LEN_W'(1);
          end else begin
            long_d = 1'b1;
            fn     = len_q;
            nokw   = 1'b1;
            len_d  = '0;
          end
        end else begin
          fn     = len_q;
          len_d  = '0;
          long_d = 1'b0;
          if (c == csc_pkg::CH_SLASH) begin
            slash_d = 1'b1;
          end else if (c == csc_pkg::CH_DQUOTE) begin
            mode_d = csc_pkg::MODE_STRING;
          end else if (c == csc_pkg::CH_SQUOTE) begin
            mode_d = csc_pkg::MODE_CHAR;
          end
          dcls = (c == csc_pkg::CH_HASH) ? csc_pkg::CLS_HASH : csc_pkg::CLS_PLAIN;
        end
      end
    endcase
    if (in_data_i.line_end) begin
      if (hold) begin
        fn = len_d;
      end
      mode_d  = csc_pkg::MODE_CODE;
      slash_d = 1'b0;
      star_d  = 1'b0;
      esc_d   = 1'b0;
      long_d  = 1'b0;
      len_d   = '0;
      col_d   = '0;
    end else if (col_inc > SUM_W'(LINE_LENGTH - 1)) begin
      col_d = COL_W'(LINE_LENGTH - 1);
    end else begin
      col_d = col_inc[COL_W-1:0];
    end
  end

  // keyword match over the held word
  always_comb begin
    word_val = '0;
    for (int k = 0; k < int'(csc_pkg::KW_MAX_LEN); k++) begin
      if (LEN_W'(k) < flen_q) begin
        word_val = {word_val[KW_W-9:0], store_q[k]};
      end
    end
    kw_hit = 1'b0;
    for (int i = 0; i < int'(csc_pkg::KW_COUNT); i++) begin
      if (word_val == csc_pkg::KW_TABLE[i]) begin
        kw_hit = 1'b1;
      end
    end
    kw_hit = kw_hit && !nokw_q && (flen_q <= LEN_W'(csc_pkg::KW_MAX_LEN));
  end

  // result selection
  always_comb begin
    fbyte     = store_q[k_q];
    fcol_sum  = SUM_W'(wcol_q) + SUM_W'(k_q);
    fcol      = (fcol_sum > SUM_W'(LINE_LENGTH - 1)) ? COL_W'(LINE_LENGTH - 1)
                                                     : fcol_sum[COL_W-1:0];
    fcls      = kw_hit ? csc_pkg::CLS_KEYWORD :
                (csc_pkg::is_digit(fbyte) ? csc_pkg::CLS_DIGIT : csc_pkg::CLS_PLAIN);
    flush_end = ((LEN_W'(k_q) + LEN_W'(1)) == flen_q);
    out_d     = out_q;
    ocls      = cmd_i.emit_flush ? fcls : dcls_q;
    if (cmd_i.emit_flush) begin
      out_d.out_byte = fbyte;
      out_d.column   = 8'(fcol);
      out_d.run_last = flush_end && !dv_q;
    end else begin
      out_d.out_byte = dbyte_q;
      out_d.column   = 8'(dcol_q);
      out_d.run_last = 1'b1;
    end
    out_d.colour_class = ocls;
    out_d.attribute    = attr_of(ocls, reg_default_q, reg_keyword_q, reg_hash_q,
                                 reg_literal_q, reg_comment_q, reg_digit_q);
    out_d.line_last    = out_d.run_last && last_q;
  end

  assign sts_o.flush_any   = (fn != '0);
  assign sts_o.direct_any  = dv;
  assign sts_o.flush_end   = flush_end;
  assign sts_o.direct_held = dv_q;
  assign sts_o.out_free    = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= csc_pkg::MODE_CODE;
      slash_q     <= 1'b0;
      star_q      <= 1'b0;
      esc_q       <= 1'b0;
      long_q      <= 1'b0;
      len_q       <= '0;
      col_q       <= '0;
      flen_q      <= '0;
      nokw_q      <= 1'b0;
      dv_q        <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        mode_q  <= mode_d;
        slash_q <= slash_d;
        star_q  <= star_d;
        esc_q   <= esc_d;
        long_q  <= long_d;
        len_q   <= len_d;
        col_q   <= col_d;
        flen_q  <= fn;
        nokw_q  <= nokw;
        dv_q    <= dv;
        k_q     <= '0;
      end else if (cmd_i.emit_flush) begin
        k_q <= k_q + WIDX'(1);
      end
      if (cmd_i.emit_flush || cmd_i.emit_direct) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_default_q <= csc_pkg::RST_DEFAULT;
      reg_keyword_q <= csc_pkg::RST_KEYWORD;
      reg_hash_q    <= csc_pkg::RST_HASH;
      reg_literal_q <= csc_pkg::RST_LITERAL;
      reg_comment_q <= csc_pkg::RST_COMMENT;
      reg_digit_q   <= csc_pkg::RST_DIGIT;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        csc_pkg::REG_DEFAULT: reg_default_q <= cfg_data_i;
        csc_pkg::REG_KEYWORD: reg_keyword_q <= cfg_data_i;
        csc_pkg::REG_HASH:    reg_hash_q    <= cfg_data_i;
        csc_pkg::REG_LITERAL: reg_literal_q <= cfg_data_i;
        csc_pkg::REG_COMMENT: reg_comment_q <= cfg_data_i;
        csc_pkg::REG_DIGIT:   reg_digit_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      wcol_q  <= wcol_d;
      dbyte_q <= c;
      dcls_q  <= dcls;
      dcol_q  <= col_q;
      last_q  <= in_data_i.line_end;
      if (hold) begin
        store_q[len_q[WIDX-1:0]] <= c;
      end
    end
    if (cmd_i.emit_flush || cmd_i.emit_direct) begin
      out_q <= out_d;
    end
  end

  a_flush_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_flush |-> (LEN_W'(k_q) < flen_q))
    else $error("flush read past the held word");

  a_one_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.emit_flush && cmd_i.emit_direct) && !(cmd_i.accept && cmd_i.emit_flush))
    else $error("conflicting datapath commands");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(WORD_HOLD))
    else $error("held word longer than the store");

  a_word_only_in_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != csc_pkg::MODE_CODE) |-> (len_q == '0) && !long_q)
    else $error("word held outside code mode");

  a_emit_on_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_flush || cmd_i.emit_direct) |-> (!out_valid_q || !out_stall_i))
    else $error("output register overwritten while stalled");

endmodule

### rtl/c_source_syntax_colorizer_top.sv
// ----------------------------------------------------------------------------
// c_source_syntax_colorizer_top
// Colors C source text one character per beat and tags each with a class
// and attribute byte.
//
//   channel  direction  handshake             payload
//   in       input      in_valid_i/in_stall_o  csc_pkg::in_item_t
//   out      output     out_valid_o/out_stall_i csc_pkg::out_item_t
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// An input beat is accepted in the idle state, then drains each result it produces:
// a held word character produces none, a character that ends a held word
// WORD_HOLD+1 at most. The held word drains one entry per cycle while the output is free.
// Reset clears lexer state and restores the colour registers.
// A stalled output holds the draining sequence; input stalls while draining.
// ----------------------------------------------------------------------------
module c_source_syntax_colorizer_top #(
  parameter int unsigned WORD_HOLD   = 8,
  parameter int unsigned LINE_LENGTH = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  csc_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output csc_pkg::out_item_t            out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [csc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]                    cfg_data_i
);

  csc_pkg::ctrl_cmd_t cmd;
  csc_pkg::ctrl_sts_t sts;

  assign cfg_ready_o = 1'b1;

  csc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  csc_datapath #(
    .WORD_HOLD   (WORD_HOLD),
    .LINE_LENGTH (LINE_LENGTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
